// ===== rtl/sorted_unique_set_store_defines.svh =====
// Assertion macros used by the checker file of the sorted set store.
`ifndef SORTED_UNIQUE_SET_STORE_DEFINES_SVH
`define SORTED_UNIQUE_SET_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SUS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication that also holds while reset is asserted.
`define SUS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sus_pkg.sv =====
// Package with field widths, operation and status codes and controller states.
package sus_pkg;

  // Field widths of the request and response transactions.
  localparam int OP_W   = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;

  // Operation codes; the unused code behaves as a find.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  // Response status codes.
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

  // One response as handed from the controller to the output register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } result_t;

  // Controller sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_EXEC,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_WR,
    S_REM_END,
    S_RESULT
  } state_t;

endpackage

// ===== rtl/sus_mem.sv =====
// Entry memory: one write port and one read port with registered read data.
module sus_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [sus_pkg::VAL_W-1:0]   wdata,
  input  logic [AW-1:0]                      raddr,
  output logic signed [sus_pkg::VAL_W-1:0]   rdata
);
  import sus_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sus_ctrl.sv =====
// Sequencer: binary search over the memory, then shifts entries to insert or remove.
module sus_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int IW       = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sus_pkg::OP_W-1:0]          operation,
  input  logic signed [sus_pkg::VAL_W-1:0]  value,
  output logic                              res_valid,
  input  logic                              res_ready,
  output sus_pkg::result_t                  res,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic signed [sus_pkg::VAL_W-1:0]  mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  logic signed [sus_pkg::VAL_W-1:0]  mem_rdata
);
  import sus_pkg::*;

  state_t                  state, state_next;
  logic [IW-1:0]           cnt, cnt_next;
  logic [IW-1:0]           lo, lo_next;
  logic [IW-1:0]           hi, hi_next;
  logic [IW-1:0]           idx, idx_next;
  logic                    found, found_next;
  logic [OP_W-1:0]         op_q, op_q_next;
  logic signed [VAL_W-1:0] val_q, val_q_next;
  logic [STAT_W-1:0]       stat_q, stat_q_next;
  logic [POS_W-1:0]        pos_q, pos_q_next;

  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid;
  logic [IW-1:0] idx_dec;
  logic [IW-1:0] idx_inc;
  logic [IW:0]   lo_plus1;
  logic [IW:0]   idx_plus2;

  // Midpoint of the search window and neighbor indexes for the shifts.
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[IW:1];
  assign idx_dec   = idx - 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign lo_plus1  = {1'b0, lo} + 1'b1;
  assign idx_plus2 = {1'b0, idx} + 2'd2;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    idx    <= idx_next;
    found  <= found_next;
    op_q   <= op_q_next;
    val_q  <= val_q_next;
    stat_q <= stat_q_next;
    pos_q  <= pos_q_next;
  end

  // Next state, memory requests and response.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    lo_next      = lo;
    hi_next      = hi;
    idx_next     = idx;
    found_next   = found;
    op_q_next    = op_q;
    val_q_next   = val_q;
    stat_q_next  = stat_q;
    pos_q_next   = pos_q;
    in_ready     = (state == S_IDLE);
    res_valid    = 1'b0;
    res.status   = stat_q;
    res.position = pos_q;
    res.count    = CNT_W'(cnt);
    mem_we       = 1'b0;
    mem_waddr    = idx[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = mid[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q_next  = operation;
          val_q_next = value;
          lo_next    = '0;
          hi_next    = cnt;
          found_next = 1'b0;
          state_next = S_SEARCH;
        end
      end

      // Issue a read of the midpoint while the window is not empty.
      S_SEARCH: begin
        mem_raddr = mid[AW-1:0];
        if (lo < hi) begin
          state_next = S_CMP;
        end else begin
          state_next = S_EXEC;
        end
      end

      // Narrow the window; the upper bound is the count or points at an entry not below the value.
      S_CMP: begin
        if (mem_rdata < val_q) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next    = mid;
          found_next = (mem_rdata == val_q);
        end
        state_next = S_SEARCH;
      end

      // The search is done: lo is the sorted position of the value.
      S_EXEC: begin
        pos_q_next = '0;
        if (op_q == OP_INSERT) begin
          if (found) begin
            stat_q_next = ST_PRESENT;
            state_next  = S_RESULT;
          end else if (cnt == IW'(CAPACITY)) begin
            stat_q_next = ST_FULL;
            state_next  = S_RESULT;
          end else begin
            stat_q_next = ST_INSERTED;
            pos_q_next  = POS_W'(lo);
            idx_next    = cnt;
            if (cnt > lo) begin
              state_next = S_INS_RD;
            end else begin
              state_next = S_INS_PUT;
            end
          end
        end else if (op_q == OP_REMOVE) begin
          if (found) begin
            stat_q_next = ST_REMOVED;
            pos_q_next  = POS_W'(lo);
            idx_next    = lo;
            if (lo_plus1 < {1'b0, cnt}) begin
              state_next = S_REM_RD;
            end else begin
              state_next = S_REM_END;
            end
          end else begin
            stat_q_next = ST_NOT_FOUND;
            state_next  = S_RESULT;
          end
        end else begin
          if (found) begin
            stat_q_next = ST_FOUND;
            pos_q_next  = POS_W'(lo);
          end else begin
            stat_q_next = ST_NOT_FOUND;
          end
          state_next = S_RESULT;
        end
      end

      // Insert: move entries up by one, from the top down to the insert position.
      S_INS_RD: begin
        mem_raddr  = idx_dec[AW-1:0];
        state_next = S_INS_WR;
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
        idx_next  = idx_dec;
        if (idx_dec > lo) begin
          state_next = S_INS_RD;
        end else begin
          state_next = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = lo[AW-1:0];
        mem_wdata  = val_q;
        cnt_next   = cnt + 1'b1;
        state_next = S_RESULT;
      end

      // Remove: move entries down by one to close the gap.
      S_REM_RD: begin
        mem_raddr  = idx_inc[AW-1:0];
        state_next = S_REM_WR;
      end

      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
        idx_next  = idx_inc;
        if (idx_plus2 < {1'b0, cnt}) begin
          state_next = S_REM_RD;
        end else begin
          state_next = S_REM_END;
        end
      end

      S_REM_END: begin
        cnt_next   = cnt - 1'b1;
        state_next = S_RESULT;
      end

      // Hold the response until the output register can take it.
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sorted_unique_set_store.sv =====
// Sorted set store of distinct signed 32-bit values answering insert, remove and find
// transactions, one response per request. The values sit in ascending order in a
// single-port-read, single-port-write memory of CAPACITY entries. A request is located
// by binary search: s steps of one memory read and one compare, with s at most
// ceil(log2(count+1)), and one more search step to see the window close. An insert
// then moves every larger entry up one place and a remove moves them down, each moved
// entry read and then written back, plus one step to write the value or update the
// count. After the step that decides the outcome, the response is handed on to the
// output register. The controller returns to idle before it takes the next request,
// and the next request is taken while the previous response still waits in the output
// register. There is no clearing pass: an empty set needs no cleared memory.
module sorted_unique_set_store #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sus_pkg::OP_W-1:0]          operation,
  input  logic signed [sus_pkg::VAL_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sus_pkg::STAT_W-1:0]        status,
  output logic [sus_pkg::POS_W-1:0]         position,
  output logic [sus_pkg::CNT_W-1:0]         count
);
  import sus_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata;
  logic                    res_valid;
  logic                    res_ready;
  result_t                 res;

  sus_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sus_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .IW       (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // The output register takes a new response when empty or being drained.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status   <= res.status;
      position <= res.position;
      count    <= res.count;
    end
  end

endmodule

// ===== rtl/sus_chk.sv =====
// Port-level checker for the sorted set store, bound to the top level.
`include "sorted_unique_set_store_defines.svh"

module sus_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sus_pkg::STAT_W-1:0]        status,
  input logic [sus_pkg::POS_W-1:0]         position,
  input logic [sus_pkg::CNT_W-1:0]         count
);
  import sus_pkg::*;

  // Only one request is in flight: the input closes right after a transaction.
  `SUS_ASSERT_NEXT(a_in_single, in_valid && in_ready, !in_ready, "request taken while one is in flight")

  // A response that is not taken keeps its contents.
  `SUS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(position) && $stable(count), "response changed while stalled")

  // Statuses that name no entry report position zero.
  `SUS_ASSERT_IMPL(a_pos_zero, out_valid && (status == ST_PRESENT || status == ST_NOT_FOUND || status == ST_FULL), position == '0, "nonzero position without an entry")

  // A successful insert, a value found or present, or a full set implies a nonempty set.
  `SUS_ASSERT_IMPL(a_count_nonempty, out_valid && (status == ST_INSERTED || status == ST_FOUND || status == ST_PRESENT || status == ST_FULL), count != '0, "empty set with an entry reported")

  // No response is pending in the cycle after reset.
  `SUS_ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid, "response pending after reset")

endmodule

bind sorted_unique_set_store sus_chk u_sus_chk (.*);
